// ----- src/particle_pool_collision_engine_macros.svh -----
// assertion macros for the particle pool collision engine
// no dependencies; included by the files that carry assertions
`ifndef PARTICLE_POOL_COLLISION_ENGINE_MACROS_SVH
`define PARTICLE_POOL_COLLISION_ENGINE_MACROS_SVH

// same-cycle implication
`define PPCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ppce_pkg.sv -----
// shared types, codes and helpers of the particle pool collision engine
// no dependencies
package ppce_pkg;

   localparam int MAX_PARTICLES_DEF = 1024;

   localparam int FUNC_W  = 3;
   localparam int POS_W   = 24;
   localparam int TAU_W   = 16;
   localparam int RAD_W   = 18;
   localparam int AREA_W  = 23;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 3;
   localparam int MUL_W   = 52;
   localparam int LIMB_W  = 25;
   localparam int BIG_W   = 2 * LIMB_W;
   localparam int PROD_W  = 2 * BIG_W;

   // command codes
   localparam logic [FUNC_W-1:0] FN_SPAWN   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_STEP    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_OVERLAP = 3'd2;
   localparam logic [FUNC_W-1:0] FN_CAST    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_BODY_RADIUS = 3'd0;
   localparam logic [CSR_W-1:0] CSR_AREA_LEFT   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_AREA_TOP    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_AREA_WIDTH  = 3'd3;
   localparam logic [CSR_W-1:0] CSR_AREA_HEIGHT = 3'd4;

   localparam logic signed [MUL_W-1:0] POS_MAX = 52'sd8388607;
   localparam logic signed [MUL_W-1:0] POS_MIN = -52'sd8388608;
   localparam logic signed [MUL_W-1:0] ROUND_HALF = 52'sd32768;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] vel_x;
      logic signed [POS_W-1:0] vel_y;
   } part_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DONE,
      ST_PREP_R, ST_PREP_T, ST_PREP_E,
      ST_SCAN_RD,
      ST_STEP_X, ST_STEP_Y, ST_STEP_W,
      ST_C_DIFF, ST_C_M1, ST_C_M2, ST_C_M3, ST_C_M4, ST_C_M5, ST_C_M6, ST_C_M7,
      ST_C_B1, ST_C_B2, ST_C_B3, ST_C_HIT,
      ST_K_INIT, ST_K_RDD, ST_K_RDE, ST_K_WR
   } state_type;

   // position plus rounded velocity times delta, saturated to 24 bits
   function automatic logic signed [POS_W-1:0] step_pos(
      input logic signed [POS_W-1:0] p,
      input logic signed [MUL_W-1:0] prod);
      logic signed [MUL_W-1:0] sum;
      sum = MUL_W'(p) + ((prod + ROUND_HALF) >>> 16);
      if (sum > POS_MAX) begin
         return POS_MAX[POS_W-1:0];
      end else if (sum < POS_MIN) begin
         return POS_MIN[POS_W-1:0];
      end
      return sum[POS_W-1:0];
   endfunction

endpackage

// ----- src/ppce_wmul.sv -----
// iterative 50 x 50 unsigned multiplier, four 25 x 25 partial products
// depends on ppce_pkg
module ppce_wmul
   import ppce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BIG_W-1:0]  op_a,
   input  logic [BIG_W-1:0]  op_b,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   localparam logic [2:0] K_LAST = 3'd4;

   logic [BIG_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [BIG_W-1:0]    pp_ff, pp_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [2:0]          k_ff, k_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [LIMB_W-1:0]   limb_a, limb_b;
   logic [2:0]          k_prev;
   logic [PROD_W-1:0]   pp_shift;

   // limb select: lo*lo, lo*hi, hi*lo, hi*hi
   assign limb_a = k_ff[1] ? a_ff[BIG_W-1:LIMB_W] : a_ff[LIMB_W-1:0];
   assign limb_b = k_ff[0] ? b_ff[BIG_W-1:LIMB_W] : b_ff[LIMB_W-1:0];
   assign k_prev = k_ff - 3'd1;

   // weight of the registered partial product, selected by the previous limb index
   always_comb begin
      case (k_prev)
         3'd0:    pp_shift = PROD_W'(pp_ff);
         3'd3:    pp_shift = PROD_W'(pp_ff) << BIG_W;
         default: pp_shift = PROD_W'(pp_ff) << LIMB_W;
      endcase
   end

   // next values
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (k_ff != K_LAST) begin
            pp_in = limb_a * limb_b;
         end
         if (k_ff != 3'd0) begin
            acc_in = acc_ff + pp_shift;
         end
         k_in = k_ff + 3'd1;
         if (k_ff == K_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         k_ff    <= k_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- src/particle_pool_collision_engine.sv -----
// Spawn, clear and unknown commands go through the done state to the result register.
// Step runs read, x, y and write per live particle, overlap read, difference, products
// and hit, cast more products and up to three through the shared iterative
// wide multiplier; compaction moves the last live entry into each hole. One item at a
// time; the result register lets the next item in while a result waits. Reset is
// synchronous: pool empty, control and config registers zero, no memory clearing pass.
`include "particle_pool_collision_engine_macros.svh"

module particle_pool_collision_engine
   import ppce_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_vel_x,
   input  logic signed [POS_W-1:0]  req_vel_y,
   input  logic [TAU_W-1:0]         req_delta_time,
   input  logic [RAD_W-1:0]         req_probe_radius,
   input  logic                     req_destroy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [COUNT_W-1:0]       rsp_removed_count,
   output logic [COUNT_W-1:0]       rsp_live_count,
   output logic                     rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [POS_W-1:0]         csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

   // state and command registers
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in, idx_ff, idx_in;
   logic [CNT_W-1:0]           ndoom_ff, ndoom_in, j_ff, j_in, removed_ff, removed_in;
   logic [FUNC_W-1:0]          func_ff, func_in;
   logic signed [POS_W-1:0]    cpx_ff, cpx_in, cpy_ff, cpy_in, cvx_ff, cvx_in, cvy_ff, cvy_in;
   logic [TAU_W-1:0]           tau_ff, tau_in;
   logic [RAD_W:0]             rr_ff, rr_in;
   logic                       destroy_ff, destroy_in, hit_ff, hit_in, status_ff, status_in;
   logic signed [POS_W:0]      right_ff, right_in, bottom_ff, bottom_in;

   // configuration registers
   logic [RAD_W-1:0]           body_ff, body_in;
   logic signed [POS_W-1:0]    left_ff, left_in, top_ff, top_in;
   logic [AREA_W-1:0]          width_ff, width_in, height_ff, height_in;

   // arithmetic registers
   logic signed [MUL_W-1:0]    prod_ff, prod_in, acc_ff, acc_in;
   logic [2*(RAD_W+1)-1:0]     r2_ff, r2_in;
   logic [2*TAU_W-1:0]         tt_ff, tt_in;
   logic signed [POS_W-1:0]    nx_ff, nx_in;
   logic signed [POS_W:0]      dpx_ff, dpx_in, dpy_ff, dpy_in, dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic signed [BIG_W:0]      c_ff, c_in;
   logic [BIG_W-1:0]           a_ff, a_in, g_ff, g_in;
   logic                       ok_ff, ok_in, br1_ff, br1_in;
   logic [PROD_W-1:0]          p1_ff, p1_in;
   logic [IDX_W-1:0]           dst_ff, dst_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]         rsp_removed_ff, rsp_removed_in, rsp_live_ff, rsp_live_in;

   // memories
   part_type                   part_mem [MAX_PARTICLES];
   logic [IDX_W-1:0]           doom_mem [MAX_PARTICLES];
   part_type                   part_rd_ff;
   logic [IDX_W-1:0]           doom_rd_ff;

   // memory and multiplier controls
   logic                       mem_re, mem_we, dm_re, dm_we;
   logic [IDX_W-1:0]           mem_raddr, mem_waddr, dm_raddr, dm_waddr, dm_wdata;
   part_type                   mem_wdata;
   logic signed [25:0]         sm_a, sm_b;
   logic                       wm_start, wm_done;
   logic [BIG_W-1:0]           wm_a, wm_b;
   logic [PROD_W-1:0]          wm_prod;

   // derived values
   logic                       req_take, rsp_free, full, keep, hit_now, cast_skip;
   logic                       cond1, scan_end;
   logic signed [POS_W-1:0]    ny_new;
   logic signed [MUL_W-1:0]    c_sum, h_sum, g_neg, a_sum;
   logic [PROD_W-1:0]          x_cmp, c_shift;
   logic [CNT_W-1:0]           jm1, cm1;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign full      = (count_ff >= CNT_W'(MAX_PARTICLES));
   assign scan_end  = (idx_ff == count_ff);
   assign jm1       = j_ff - 1'b1;
   assign cm1       = count_ff - 1'b1;

   // step: new y and the inside test
   assign ny_new = step_pos(part_rd_ff.pos_y, prod_ff);
   assign keep   = (nx_ff > left_ff) && ((POS_W+1)'(nx_ff) < right_ff) &&
                   (ny_new > top_ff) && ((POS_W+1)'(ny_new) < bottom_ff);

   // collision sums
   assign c_sum  = acc_ff + prod_ff - $signed(MUL_W'(r2_ff));
   assign h_sum  = acc_ff + prod_ff;
   assign a_sum  = acc_ff + prod_ff;
   assign g_neg  = -h_sum;
   assign cast_skip = c_ff[BIG_W] || (a_ff == '0) || (h_sum > 0);
   assign hit_now   = c_ff[BIG_W] || ok_ff;

   // contact time against the window: g * 2^16 versus a * tau
   assign x_cmp   = PROD_W'({g_ff, 16'b0});
   assign cond1   = (x_cmp < wm_prod) || ((x_cmp == wm_prod) && destroy_ff);
   assign c_shift = PROD_W'({c_ff[BIG_W-1:0], 32'b0});

   // shared wide multiplier
   ppce_wmul u_wmul (
      .clock   (clock),
      .reset   (reset),
      .start   (wm_start),
      .op_a    (wm_a),
      .op_b    (wm_b),
      .done    (wm_done),
      .product (wm_prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  FN_STEP:             state_in = ST_SCAN_RD;
                  FN_OVERLAP, FN_CAST: state_in = ST_PREP_R;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_PREP_R:  state_in = ST_PREP_T;
         ST_PREP_T:  state_in = ST_PREP_E;
         ST_PREP_E:  state_in = ST_SCAN_RD;
         ST_SCAN_RD: begin
            if (scan_end) begin
               state_in = ST_K_INIT;
            end else if (func_ff == FN_STEP) begin
               state_in = ST_STEP_X;
            end else begin
               state_in = ST_C_DIFF;
            end
         end
         ST_STEP_X:  state_in = ST_STEP_Y;
         ST_STEP_Y:  state_in = ST_STEP_W;
         ST_STEP_W:  state_in = ST_SCAN_RD;
         ST_C_DIFF:  state_in = ST_C_M1;
         ST_C_M1:    state_in = ST_C_M2;
         ST_C_M2:    state_in = ST_C_M3;
         ST_C_M3:    state_in = (func_ff == FN_OVERLAP) ? ST_C_HIT : ST_C_M4;
         ST_C_M4:    state_in = ST_C_M5;
         ST_C_M5:    state_in = ST_C_M6;
         ST_C_M6:    state_in = ST_C_M7;
         ST_C_M7:    state_in = cast_skip ? ST_C_HIT : ST_C_B1;
         ST_C_B1: begin
            if (wm_done) begin
               state_in = ST_C_B2;
            end
         end
         ST_C_B2: begin
            if (wm_done) begin
               state_in = ST_C_B3;
            end
         end
         ST_C_B3: begin
            if (wm_done) begin
               state_in = ST_C_HIT;
            end
         end
         ST_C_HIT:   state_in = (hit_now && !destroy_ff) ? ST_K_INIT : ST_SCAN_RD;
         ST_K_INIT:  state_in = ST_K_RDD;
         ST_K_RDD:   state_in = (j_ff == '0) ? ST_DONE : ST_K_RDE;
         ST_K_RDE:   state_in = ST_K_WR;
         ST_K_WR:    state_in = ST_K_RDD;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory, multiplier and wide multiplier controls
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = idx_ff[IDX_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = part_rd_ff;
      dm_re     = 1'b0;
      dm_raddr  = jm1[IDX_W-1:0];
      dm_we     = 1'b0;
      dm_waddr  = ndoom_ff[IDX_W-1:0];
      dm_wdata  = idx_ff[IDX_W-1:0];
      sm_a      = '0;
      sm_b      = '0;
      wm_start  = 1'b0;
      wm_a      = a_ff;
      wm_b      = BIG_W'(tau_ff);
      case (state_ff)
         ST_IDLE: begin
            // spawn writes straight into the next free entry
            if (req_take && (req_func == FN_SPAWN) && !full) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[IDX_W-1:0];
               mem_wdata = '{pos_x: req_pos_x, pos_y: req_pos_y,
                             vel_x: req_vel_x, vel_y: req_vel_y};
            end
         end
         ST_PREP_R: begin
            sm_a = $signed(26'(rr_ff));
            sm_b = $signed(26'(rr_ff));
         end
         ST_PREP_T: begin
            sm_a = $signed(26'(tau_ff));
            sm_b = $signed(26'(tau_ff));
         end
         ST_SCAN_RD: begin
            mem_re = !scan_end;
         end
         ST_STEP_X: begin
            sm_a = 26'(part_rd_ff.vel_x);
            sm_b = $signed(26'(tau_ff));
         end
         ST_STEP_Y: begin
            sm_a = 26'(part_rd_ff.vel_y);
            sm_b = $signed(26'(tau_ff));
         end
         ST_STEP_W: begin
            mem_we    = 1'b1;
            mem_wdata = '{pos_x: nx_ff, pos_y: ny_new,
                          vel_x: part_rd_ff.vel_x, vel_y: part_rd_ff.vel_y};
            dm_we     = !keep;
         end
         ST_C_M1: begin
            sm_a = 26'(dpx_ff);
            sm_b = 26'(dpx_ff);
         end
         ST_C_M2: begin
            sm_a = 26'(dpy_ff);
            sm_b = 26'(dpy_ff);
         end
         ST_C_M3: begin
            sm_a = 26'(dvx_ff);
            sm_b = 26'(dvx_ff);
         end
         ST_C_M4: begin
            sm_a = 26'(dvy_ff);
            sm_b = 26'(dvy_ff);
         end
         ST_C_M5: begin
            sm_a = 26'(dpx_ff);
            sm_b = 26'(dvx_ff);
         end
         ST_C_M6: begin
            sm_a = 26'(dpy_ff);
            sm_b = 26'(dvy_ff);
         end
         ST_C_M7: begin
            // a * tau for the window test
            wm_start = !cast_skip;
         end
         ST_C_B1: begin
            wm_start = wm_done;
            if (cond1) begin
               wm_a = g_ff;
               wm_b = g_ff;
            end else begin
               wm_b = BIG_W'(tt_ff);
            end
         end
         ST_C_B2: begin
            wm_start = wm_done;
            if (br1_ff) begin
               wm_b = c_ff[BIG_W-1:0];
            end else begin
               wm_a = g_ff;
               wm_b = BIG_W'({tau_ff, 17'b0});
            end
         end
         ST_C_HIT: begin
            dm_we = hit_now && destroy_ff;
         end
         ST_K_RDD: begin
            dm_re = (j_ff != '0);
         end
         ST_K_RDE: begin
            // last live entry moves into the hole
            mem_re    = 1'b1;
            mem_raddr = cm1[IDX_W-1:0];
         end
         ST_K_WR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      ndoom_in   = ndoom_ff;
      j_in       = j_ff;
      removed_in = removed_ff;
      func_in    = func_ff;
      cpx_in     = cpx_ff;
      cpy_in     = cpy_ff;
      cvx_in     = cvx_ff;
      cvy_in     = cvy_ff;
      tau_in     = tau_ff;
      rr_in      = rr_ff;
      destroy_in = destroy_ff;
      hit_in     = hit_ff;
      status_in  = status_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      prod_in    = sm_a * sm_b;
      acc_in     = acc_ff;
      r2_in      = r2_ff;
      tt_in      = tt_ff;
      nx_in      = nx_ff;
      dpx_in     = dpx_ff;
      dpy_in     = dpy_ff;
      dvx_in     = dvx_ff;
      dvy_in     = dvy_ff;
      c_in       = c_ff;
      a_in       = a_ff;
      g_in       = g_ff;
      ok_in      = ok_ff;
      br1_in     = br1_ff;
      p1_in      = p1_ff;
      dst_in     = dst_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in    = req_func;
               cpx_in     = req_pos_x;
               cpy_in     = req_pos_y;
               cvx_in     = req_vel_x;
               cvy_in     = req_vel_y;
               tau_in     = req_delta_time;
               rr_in      = (RAD_W+1)'(body_ff) + (RAD_W+1)'(req_probe_radius);
               destroy_in = req_destroy;
               right_in   = (POS_W+1)'(left_ff) + $signed((POS_W+1)'(width_ff));
               bottom_in  = (POS_W+1)'(top_ff) + $signed((POS_W+1)'(height_ff));
               idx_in     = '0;
               ndoom_in   = '0;
               hit_in     = 1'b0;
               removed_in = '0;
               status_in  = 1'b0;
               case (req_func)
                  FN_SPAWN: begin
                     if (full) begin
                        status_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FN_CLEAR: begin
                     removed_in = count_ff;
                     count_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP_T: r2_in = prod_ff[2*(RAD_W+1)-1:0];
         ST_PREP_E: tt_in = prod_ff[2*TAU_W-1:0];
         ST_STEP_Y: nx_in = step_pos(part_rd_ff.pos_x, prod_ff);
         ST_STEP_W: begin
            idx_in = idx_ff + 1'b1;
            if (!keep) begin
               ndoom_in = ndoom_ff + 1'b1;
            end
         end
         ST_C_DIFF: begin
            // probe minus particle
            dpx_in = (POS_W+1)'(cpx_ff) - (POS_W+1)'(part_rd_ff.pos_x);
            dpy_in = (POS_W+1)'(cpy_ff) - (POS_W+1)'(part_rd_ff.pos_y);
            dvx_in = (POS_W+1)'(cvx_ff) - (POS_W+1)'(part_rd_ff.vel_x);
            dvy_in = (POS_W+1)'(cvy_ff) - (POS_W+1)'(part_rd_ff.vel_y);
            ok_in  = 1'b0;
         end
         ST_C_M2: acc_in = prod_ff;
         ST_C_M3: c_in   = c_sum[BIG_W:0];
         ST_C_M4: acc_in = prod_ff;
         ST_C_M5: a_in   = a_sum[BIG_W-1:0];
         ST_C_M6: acc_in = prod_ff;
         ST_C_M7: g_in   = g_neg[BIG_W-1:0];
         ST_C_B1: begin
            if (wm_done) begin
               br1_in = cond1;
            end
         end
         ST_C_B2: begin
            if (wm_done) begin
               p1_in = br1_ff ? wm_prod : (wm_prod + c_shift);
            end
         end
         ST_C_B3: begin
            if (wm_done) begin
               if (br1_ff) begin
                  ok_in = (p1_ff >= wm_prod);
               end else begin
                  ok_in = (p1_ff < wm_prod) || ((p1_ff == wm_prod) && destroy_ff);
               end
            end
         end
         ST_C_HIT: begin
            if (hit_now) begin
               hit_in = 1'b1;
            end
            if (hit_now && destroy_ff) begin
               ndoom_in = ndoom_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
            end else if (!hit_now) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_K_INIT: begin
            j_in       = ndoom_ff;
            removed_in = ndoom_ff;
         end
         ST_K_RDD: begin
            if (j_ff != '0) begin
               j_in = jm1;
            end
         end
         ST_K_RDE: begin
            dst_in   = doom_rd_ff;
            count_in = cm1;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_status_in  = rsp_status_ff;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit_ff;
         rsp_removed_in = COUNT_W'(removed_ff);
         rsp_live_in    = COUNT_W'(count_ff);
         rsp_status_in  = status_ff;
      end
   end

   // configuration writes
   always_comb begin
      body_in   = body_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BODY_RADIUS: body_in   = csr_wdata[RAD_W-1:0];
            CSR_AREA_LEFT:   left_in   = csr_wdata;
            CSR_AREA_TOP:    top_in    = csr_wdata;
            CSR_AREA_WIDTH:  width_in  = csr_wdata[AREA_W-1:0];
            CSR_AREA_HEIGHT: height_in = csr_wdata[AREA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         body_ff      <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         body_ff      <= body_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      ndoom_ff       <= ndoom_in;
      j_ff           <= j_in;
      removed_ff     <= removed_in;
      func_ff        <= func_in;
      cpx_ff         <= cpx_in;
      cpy_ff         <= cpy_in;
      cvx_ff         <= cvx_in;
      cvy_ff         <= cvy_in;
      tau_ff         <= tau_in;
      rr_ff          <= rr_in;
      destroy_ff     <= destroy_in;
      hit_ff         <= hit_in;
      status_ff      <= status_in;
      right_ff       <= right_in;
      bottom_ff      <= bottom_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      r2_ff          <= r2_in;
      tt_ff          <= tt_in;
      nx_ff          <= nx_in;
      dpx_ff         <= dpx_in;
      dpy_ff         <= dpy_in;
      dvx_ff         <= dvx_in;
      dvy_ff         <= dvy_in;
      c_ff           <= c_in;
      a_ff           <= a_in;
      g_ff           <= g_in;
      ok_ff          <= ok_in;
      br1_ff         <= br1_in;
      p1_ff          <= p1_in;
      dst_ff         <= dst_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // particle memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         part_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         part_rd_ff <= part_mem[mem_raddr];
      end
   end

   // removal list memory
   always_ff @(posedge clock) begin
      if (dm_we) begin
         doom_mem[dm_waddr] <= dm_wdata;
      end
      if (dm_re) begin
         doom_rd_ff <= doom_mem[dm_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_live_count    = rsp_live_ff;
   assign rsp_status        = rsp_status_ff;

   // checks
   `PPCE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_PARTICLES), "live count beyond pool depth")
   `PPCE_ASSERT_IMP(a_doom_le_scan, clock, reset, state_ff != ST_IDLE, ndoom_ff <= idx_ff, "more removals than scanned entries")
   `PPCE_ASSERT_IMP(a_wmul_done, clock, reset, wm_done, (state_ff == ST_C_B1) || (state_ff == ST_C_B2) || (state_ff == ST_C_B3), "wide product finished outside a wait state")
   `PPCE_ASSERT_NXT(a_compact_dec, clock, reset, state_ff == ST_K_RDE, count_ff == $past(count_ff) - 1'b1, "compaction did not drop one entry")
   `PPCE_ASSERT_NXT(a_rsp_drain, clock, reset, rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE), !rsp_valid_ff, "taken result still shown")

endmodule

// ----- verif/tb_particle_pool_collision_engine.sv -----
// self-checking testbench for particle_pool_collision_engine
// depends on ppce_pkg and the engine rtl; a built-in pool predictor checks untyped results
`timescale 1ns / 1ps

module tb_particle_pool_collision_engine;
   import ppce_pkg::*;

   localparam int POOL_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 2000;

   typedef struct {
      logic [FUNC_W-1:0]       func;
      logic signed [POS_W-1:0] px, py, vx, vy;
      logic [TAU_W-1:0]        dt;
      logic [RAD_W-1:0]        pr;
      logic                    ds;
   } pool_cmd_type;

   typedef struct {
      logic               hit;
      logic [COUNT_W-1:0] removed;
      logic [COUNT_W-1:0] live;
      logic               status;
   } pool_outcome_type;

   typedef struct {
      pool_cmd_type     cmd;
      bit               typed;
      pool_outcome_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_vel_x = '0, req_vel_y = '0;
   logic [TAU_W-1:0] req_delta_time = '0;
   logic [RAD_W-1:0] req_probe_radius = '0;
   logic req_destroy = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [COUNT_W-1:0] rsp_removed_count, rsp_live_count;
   logic rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic [POS_W-1:0] csr_wdata = '0;

   particle_pool_collision_engine dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [RAD_W-1:0] cfg_radius;
   longint cfg_left, cfg_top, cfg_width, cfg_height;
   logic signed [POS_W-1:0] pool_x [POOL_DEPTH];
   logic signed [POS_W-1:0] pool_y [POOL_DEPTH];
   logic signed [POS_W-1:0] pool_vx [POOL_DEPTH];
   logic signed [POS_W-1:0] pool_vy [POOL_DEPTH];
   int doomed [POOL_DEPTH];
   int pool_live;

   pool_outcome_type outcome_q[$];
   int errors;
   int mismatches;
   int cycles;
   bit quiet;
   bit hold_req;
   int hold_left;

   function automatic longint sat_pos(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // exact first-contact test of a moving probe within the window
   function automatic bit contact_in_window(longint dpx, longint dpy, longint dvx, longint dvy,
                                            longint c, longint tau, bit strict_end);
      logic [127:0] a, g, t, lhs, rhs;
      longint h;
      a = 128'(dvx * dvx + dvy * dvy);
      h = dpx * dvx + dpy * dvy;
      if (a == 0 || h > 0) return 1'b0;
      g = 128'(-h);
      t = 128'(tau);
      lhs = g * 128'd65536;
      rhs = a * t;
      if (lhs < rhs || (lhs == rhs && !strict_end))
         return (g * g) >= (a * 128'(c));
      lhs = a * t * t + (128'(c) << 32);
      rhs = g * (t << 17);
      return lhs < rhs || (lhs == rhs && !strict_end);
   endfunction

   // remove doomed entries, highest index first, filling from the tail
   function automatic void pool_compact(int n);
      int idx;
      for (int j = n - 1; j >= 0; j--) begin
         idx = doomed[j];
         if (pool_live == 0) continue;
         pool_live--;
         pool_x[idx] = pool_x[pool_live];
         pool_y[idx] = pool_y[pool_live];
         pool_vx[idx] = pool_vx[pool_live];
         pool_vy[idx] = pool_vy[pool_live];
      end
   endfunction

   function automatic pool_outcome_type pool_apply(pool_cmd_type cmd);
      pool_outcome_type r;
      int n;
      longint nx, ny, r2, dpx, dpy, c;
      bit h;
      r = '{default: '0};
      n = 0;
      r2 = (longint'(cfg_radius) + longint'(cmd.pr)) ** 2;
      case (cmd.func)
         FN_SPAWN: begin
            if (pool_live >= POOL_DEPTH) begin
               r.status = 1'b1;
            end else begin
               pool_x[pool_live] = cmd.px;
               pool_y[pool_live] = cmd.py;
               pool_vx[pool_live] = cmd.vx;
               pool_vy[pool_live] = cmd.vy;
               pool_live++;
            end
         end
         FN_STEP: begin
            for (int i = 0; i < pool_live; i++) begin
               nx = longint'(pool_x[i]) + ((longint'(pool_vx[i]) * longint'(cmd.dt) + 32768) >>> 16);
               ny = longint'(pool_y[i]) + ((longint'(pool_vy[i]) * longint'(cmd.dt) + 32768) >>> 16);
               nx = sat_pos(nx);
               ny = sat_pos(ny);
               pool_x[i] = nx[POS_W-1:0];
               pool_y[i] = ny[POS_W-1:0];
               if (!(nx > cfg_left && nx < cfg_left + cfg_width &&
                     ny > cfg_top && ny < cfg_top + cfg_height))
                  doomed[n++] = i;
            end
            r.removed = COUNT_W'(n);
            pool_compact(n);
         end
         FN_OVERLAP, FN_CAST: begin
            for (int i = 0; i < pool_live; i++) begin
               dpx = longint'(cmd.px) - longint'(pool_x[i]);
               dpy = longint'(cmd.py) - longint'(pool_y[i]);
               c = dpx * dpx + dpy * dpy - r2;
               if (c < 0) h = 1'b1;
               else if (cmd.func == FN_OVERLAP) h = 1'b0;
               else h = contact_in_window(dpx, dpy,
                                          longint'(cmd.vx) - longint'(pool_vx[i]),
                                          longint'(cmd.vy) - longint'(pool_vy[i]),
                                          c, longint'(cmd.dt), !cmd.ds);
               if (h) begin
                  r.hit = 1'b1;
                  if (!cmd.ds) break;
                  doomed[n++] = i;
               end
            end
            r.removed = COUNT_W'(n);
            pool_compact(n);
         end
         FN_CLEAR: begin
            r.removed = COUNT_W'(pool_live);
            pool_live = 0;
         end
         default: ;
      endcase
      r.live = COUNT_W'(pool_live);
      return r;
   endfunction

   // receiver: random stall, long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 16);
      end
   end

   // result checker
   always @(posedge clock) begin
      pool_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            errors++;
            if (mismatches++ < 10)
               $display("unexpected result: hit %0d removed %0d live %0d status %0d",
                        rsp_hit, rsp_removed_count, rsp_live_count, rsp_status);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_hit !== want.hit || rsp_removed_count !== want.removed ||
                rsp_live_count !== want.live || rsp_status !== want.status) begin
               errors++;
               if (mismatches++ < 10)
                  $display("mismatch: exp hit %0d removed %0d live %0d status %0d, got %0d %0d %0d %0d",
                           want.hit, want.removed, want.live, want.status,
                           rsp_hit, rsp_removed_count, rsp_live_count, rsp_status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // send one item; typed expectation overrides the predicted one
   task automatic send_cmd(pool_cmd_type cmd, bit typed = 1'b0,
                           pool_outcome_type want = '{default: '0});
      pool_outcome_type got;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= cmd.func;
      req_pos_x <= cmd.px;
      req_pos_y <= cmd.py;
      req_vel_x <= cmd.vx;
      req_vel_y <= cmd.vy;
      req_delta_time <= cmd.dt;
      req_probe_radius <= cmd.pr;
      req_destroy <= cmd.ds;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = pool_apply(cmd);
      outcome_q.push_back(typed ? want : got);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outcome_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // register write, only with the engine idle
   task automatic write_reg(logic [CSR_W-1:0] idx, logic [POS_W-1:0] val);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BODY_RADIUS: cfg_radius = val[RAD_W-1:0];
         CSR_AREA_LEFT:   cfg_left = longint'($signed(val));
         CSR_AREA_TOP:    cfg_top = longint'($signed(val));
         CSR_AREA_WIDTH:  cfg_width = longint'(val[AREA_W-1:0]);
         CSR_AREA_HEIGHT: cfg_height = longint'(val[AREA_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_area(longint left, longint top, longint w, longint h);
      write_reg(CSR_AREA_LEFT, left[POS_W-1:0]);
      write_reg(CSR_AREA_TOP, top[POS_W-1:0]);
      write_reg(CSR_AREA_WIDTH, w[POS_W-1:0]);
      write_reg(CSR_AREA_HEIGHT, h[POS_W-1:0]);
   endtask

   function automatic logic signed [POS_W-1:0] near(longint base, int span);
      longint v;
      v = sat_pos(base + longint'($urandom_range(0, 2 * span)) - span);
      return v[POS_W-1:0];
   endfunction

   // random command: mostly well-formed traffic around the live particles
   function automatic pool_cmd_type random_cmd();
      pool_cmd_type cmd;
      int roll, idx;
      int span;
      cmd.px = POS_W'($urandom); cmd.py = POS_W'($urandom);
      cmd.vx = POS_W'($urandom); cmd.vy = POS_W'($urandom);
      cmd.dt = TAU_W'($urandom);
      cmd.pr = RAD_W'($urandom_range(0, 256000));
      cmd.ds = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 10) begin
         cmd.func = FUNC_W'($urandom_range(7));
         return cmd;
      end
      span = 4 * (int'(cfg_radius) + 1024);
      cmd.pr = RAD_W'($urandom_range(0, 2048));
      if (roll < 14) cmd.func = FN_CLEAR;
      else if (roll < 16) cmd.func = FUNC_W'($urandom_range(5, 7));
      else if (roll < 48) begin
         cmd.func = FN_SPAWN;
         cmd.px = near(cfg_left + cfg_width / 2, int'(cfg_width / 2));
         cmd.py = near(cfg_top + cfg_height / 2, int'(cfg_height / 2));
         cmd.vx = near(0, 40000);
         cmd.vy = near(0, 40000);
      end else if (roll < 64) begin
         cmd.func = FN_STEP;
         cmd.dt = TAU_W'($urandom_range(0, 8000));
      end else begin
         cmd.func = (roll < 82) ? FN_OVERLAP : FN_CAST;
         idx = (pool_live > 0) ? $urandom_range(0, pool_live - 1) : 0;
         cmd.px = near(pool_x[idx], span);
         cmd.py = near(pool_y[idx], span);
         cmd.vx = near(pool_vx[idx], span);
         cmd.vy = near(pool_vy[idx], span);
      end
      return cmd;
   endfunction

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if (k == count / 3) hold_req = 1'b1;
         if (k == count / 2) drain();
         send_cmd(random_cmd());
      end
   endtask

   directed_row_type rows[$];

   task automatic add_row(logic [FUNC_W-1:0] f, longint px, longint py, longint vx, longint vy,
                          int dt, int pr, bit ds, bit typed = 0, int eh = 0, int er = 0,
                          int el = 0, int es = 0);
      directed_row_type row;
      row.cmd = '{f, px[POS_W-1:0], py[POS_W-1:0], vx[POS_W-1:0], vy[POS_W-1:0],
                  dt[TAU_W-1:0], pr[RAD_W-1:0], ds};
      row.typed = typed;
      row.want = '{eh[0], er[COUNT_W-1:0], el[COUNT_W-1:0], es[0]};
      rows.push_back(row);
   endtask

   initial begin
      pool_cmd_type cmd;
      cfg_radius = '0;
      cfg_left = 0; cfg_top = 0; cfg_width = 0; cfg_height = 0;
      pool_live = 0;
      errors = 0; mismatches = 0; cycles = 0;
      quiet = 1'b0; hold_req = 1'b0; hold_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: widest area and a small body radius
      write_reg(CSR_BODY_RADIUS, 24'd256);
      set_area(-8388608, -8388608, 8388607, 8388607);
      add_row(FN_STEP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(FN_OVERLAP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(FN_CAST, 0, 0, 100, 0, 65535, 256000, 1, 1, 0, 0, 0, 0);
      add_row(FN_SPAWN, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 1, 0, 0, 1, 0);
      add_row(FN_SPAWN, -8388608, -8388608, -8388608, -8388608, 0, 0, 0, 1, 0, 0, 2, 0);
      add_row(FN_SPAWN, -100000, -100000, 256, 256, 0, 0, 0, 1, 0, 0, 3, 0);
      add_row(FN_SPAWN, -300000, -100000, 0, 0, 0, 0, 0, 1, 0, 0, 4, 0);
      add_row(FN_OVERLAP, -100000, -100000, 0, 0, 0, 0, 0);
      add_row(FN_OVERLAP, -200000, -200000, 0, 0, 0, 100, 1);
      add_row(FN_CAST, -302560, -100000, 2560, 0, 65535, 0, 0);
      add_row(FN_CAST, -110000, -100000, 256, 256, 65535, 0, 0);
      add_row(FN_CAST, -300000, -103000, 0, 3000, 65535, 256, 1);
      add_row(FN_STEP, 0, 0, 0, 0, 65535, 0, 0);
      add_row(FN_STEP, 0, 0, 0, 0, 1, 0, 0);
      add_row(3'd5, 1, 2, 3, 4, 5, 6, 1);
      add_row(3'd6, 0, 0, 0, 0, 0, 0, 0);
      add_row(3'd7, -1, -1, -1, -1, 65535, 256000, 1);
      add_row(FN_OVERLAP, 0, 0, 0, 0, 0, 256000, 1);
      add_row(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      add_row(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(FN_SPAWN, 5, 5, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
      add_row(FN_CLEAR, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0, 0);
      foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);

      // fill the pool past capacity, then sweep it empty with a zero area
      for (int k = 0; k <= POOL_DEPTH; k++) begin
         cmd = '{FN_SPAWN, near(-4194304, 4000000), near(-4194304, 4000000),
                 POS_W'($urandom), POS_W'($urandom), 0, 0, 0};
         send_cmd(cmd);
      end
      write_reg(CSR_AREA_WIDTH, '0);
      cmd = '{FN_STEP, 0, 0, 0, 0, 16'($urandom), 0, 0};
      send_cmd(cmd);

      // random, moderate area and radius
      write_reg(CSR_BODY_RADIUS, 24'($urandom_range(512, 1024)));
      set_area(-40000, -40000, 80000, 80000);
      random_phase(110);

      // random with no idling at first, largest radius
      write_reg(CSR_BODY_RADIUS, 24'd256000);
      set_area(-30000, -50000, 60000, 100000);
      quiet = 1'b1;
      random_phase(40);
      quiet = 1'b0;
      random_phase(50);

      // random, zero radius, area pinned to the top extremes
      write_reg(CSR_BODY_RADIUS, '0);
      set_area(8388607 - 60000, 8388607 - 60000, 8388607, 8388607);
      random_phase(90);

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
